@@ hdl/cri_pkg.sv @@
package cri_pkg;

	localparam int unsigned FuncWidth = 5;
	localparam int unsigned InDataWidth = 40;
	localparam int unsigned OutDataWidth = 80;

	localparam int unsigned FlagC = 0;
	localparam int unsigned FlagZ = 1;
	localparam int unsigned FlagI = 2;
	localparam int unsigned FlagD = 3;
	localparam int unsigned FlagV = 4;
	localparam int unsigned FlagN = 5;

	localparam logic [7:0] ByteMask = 8'hff;
	localparam logic [7:0] SignBit = 8'h80;

	typedef enum logic [FuncWidth-1:0] {
		FUNC_ADC = 5'd0,
		FUNC_CLC = 5'd1,
		FUNC_CLD = 5'd2,
		FUNC_CLI = 5'd3,
		FUNC_CLV = 5'd4,
		FUNC_DEX = 5'd5,
		FUNC_DEY = 5'd6,
		FUNC_INC = 5'd7,
		FUNC_INX = 5'd8,
		FUNC_INY = 5'd9,
		FUNC_NOP = 5'd10,
		FUNC_SEC = 5'd11,
		FUNC_SED = 5'd12,
		FUNC_SEI = 5'd13,
		FUNC_TAX = 5'd14,
		FUNC_TAY = 5'd15,
		FUNC_TSX = 5'd16,
		FUNC_TXA = 5'd17,
		FUNC_TXS = 5'd18,
		FUNC_TYA = 5'd19
	} func_t;

	typedef struct packed {
		logic [7:0]  mem_value;
		logic [15:0] mem_address;
		logic [7:0]  operand_value;
		logic [1:0]  pc_step;
		logic [FuncWidth-1:0] func;
	} item_t;

	function automatic logic [5:0] set_nz(input logic [5:0] f, input logic [7:0] v);
		logic [5:0] r;
		r = f;
		r[FlagN] = (v & SignBit) != 8'h00;
		r[FlagZ] = v == 8'h00;
		return r;
	endfunction

endpackage

@@ hdl/cpu_register_instruction_execute.sv @@
// Executes one instruction of a small 6502 subset per item against the held
// A, X, Y, SP, PC and flag registers (C, Z, I, D, V, N); ADC is always binary.
// One item is accepted per clock while results are taken; its result reaches the
// output through the input register, then the result register. That rate is set
// by the 8-bit ADC add and flag update, which closes the register feedback loop
// through the result register. The result register is the architectural state
// itself, so the next item moves forward as soon as the current result is
// taken; while a result waits, the input register holds one further item and
// then stalls the input.
module cpu_register_instruction_execute
	import cri_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// operand_value[7:0], mem_address[23:8], mem_value[31:24], pc_step[33:32]
	input  logic [InDataWidth-1:0]  s_axis_tdata,
	// func[4:0]
	input  logic [FuncWidth-1:0]    s_axis_tuser,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// acc[7:0], index_x[15:8], index_y[23:16], stack_ptr[31:24],
	// prog_counter[47:32], flags[53:48], write_enable[54],
	// write_address[70:55], write_data[78:71]
	output logic [OutDataWidth-1:0] m_axis_tdata
);

	logic        valid_s1;
	item_t       item_s1;
	logic        advance;

	logic        out_valid_q;
	logic [7:0]  acc_q;
	logic [7:0]  x_q;
	logic [7:0]  y_q;
	logic [7:0]  sp_q;
	logic [15:0] pc_q;
	logic [5:0]  flags_q;
	logic        we_q;
	logic [15:0] waddr_q;
	logic [7:0]  wdata_q;

	logic [7:0]  acc_d;
	logic [7:0]  x_d;
	logic [7:0]  y_d;
	logic [7:0]  sp_d;
	logic [5:0]  flags_d;
	logic [1:0]  adv;
	logic        we_d;
	logic [15:0] waddr_d;
	logic [7:0]  wdata_d;
	logic [8:0]  sum;
	logic [7:0]  inc_val;

	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.func          <= s_axis_tuser;
			item_s1.operand_value <= s_axis_tdata[7:0];
			item_s1.mem_address   <= s_axis_tdata[23:8];
			item_s1.mem_value     <= s_axis_tdata[31:24];
			item_s1.pc_step       <= s_axis_tdata[33:32];
		end
	end

	assign sum = {1'b0, acc_q} + {1'b0, item_s1.operand_value} + {8'h00, flags_q[FlagC]};
	assign inc_val = item_s1.mem_value + 8'd1;

	always_comb begin
		acc_d   = acc_q;
		x_d     = x_q;
		y_d     = y_q;
		sp_d    = sp_q;
		flags_d = flags_q;
		adv     = 2'd1;
		we_d    = 1'b0;
		waddr_d = 16'h0000;
		wdata_d = 8'h00;
		unique case (func_t'(item_s1.func))
			FUNC_ADC: begin
				acc_d          = sum[7:0];
				flags_d[FlagC] = sum[8];
				flags_d[FlagV] = ((~(acc_q ^ item_s1.operand_value)) & (acc_q ^ sum[7:0])
					& SignBit) != 8'h00;
				flags_d        = set_nz(flags_d, sum[7:0]);
				adv            = item_s1.pc_step;
			end
			FUNC_CLC: flags_d[FlagC] = 1'b0;
			FUNC_CLD: flags_d[FlagD] = 1'b0;
			FUNC_CLI: flags_d[FlagI] = 1'b0;
			FUNC_CLV: flags_d[FlagV] = 1'b0;
			FUNC_DEX: begin
				x_d     = x_q - 8'd1;
				flags_d = set_nz(flags_q, x_d);
			end
			FUNC_DEY: begin
				y_d     = y_q - 8'd1;
				flags_d = set_nz(flags_q, y_d);
			end
			FUNC_INC: begin
				we_d    = 1'b1;
				waddr_d = item_s1.mem_address;
				wdata_d = inc_val & ByteMask;
				flags_d = set_nz(flags_q, inc_val);
				adv     = item_s1.pc_step;
			end
			FUNC_INX: begin
				x_d     = x_q + 8'd1;
				flags_d = set_nz(flags_q, x_d);
			end
			FUNC_INY: begin
				y_d     = y_q + 8'd1;
				flags_d = set_nz(flags_q, y_d);
			end
			FUNC_SEC: flags_d[FlagC] = 1'b1;
			FUNC_SED: flags_d[FlagD] = 1'b1;
			FUNC_SEI: flags_d[FlagI] = 1'b1;
			FUNC_TAX: begin
				x_d     = acc_q;
				flags_d = set_nz(flags_q, acc_q);
			end
			FUNC_TAY: begin
				y_d     = acc_q;
				flags_d = set_nz(flags_q, acc_q);
			end
			FUNC_TSX: begin
				x_d     = sp_q;
				flags_d = set_nz(flags_q, sp_q);
			end
			FUNC_TXA: begin
				acc_d   = x_q;
				flags_d = set_nz(flags_q, x_q);
			end
			FUNC_TXS: sp_d = x_q;
			FUNC_TYA: begin
				acc_d   = y_q;
				flags_d = set_nz(flags_q, y_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			acc_q       <= 8'h00;
			x_q         <= 8'h00;
			y_q         <= 8'h00;
			sp_q        <= 8'h00;
			pc_q        <= 16'h0000;
			flags_q     <= 6'h00;
			we_q        <= 1'b0;
			waddr_q     <= 16'h0000;
			wdata_q     <= 8'h00;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				acc_q       <= acc_d;
				x_q         <= x_d;
				y_q         <= y_d;
				sp_q        <= sp_d;
				pc_q        <= pc_q + {14'h0000, adv};
				flags_q     <= flags_d;
				we_q        <= we_d;
				waddr_q     <= waddr_d;
				wdata_q     <= wdata_d;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, wdata_q, waddr_q, we_q, flags_q, pc_q, sp_q, y_q, x_q, acc_q};

	// hold the input register while the result waits
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input register lost an item");

	a_no_write_fields: assert property (@(posedge clk) disable iff (!arst_n)
		!we_q |-> waddr_q == 16'h0000 && wdata_q == 8'h00)
		else $error("write fields set without a write");

	a_inc_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		we_q |-> flags_q[FlagZ] == (wdata_q == 8'h00) && flags_q[FlagN] == wdata_q[7])
		else $error("INC flags disagree with written byte");

	a_state_held: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(acc_q) && $stable(pc_q) && $stable(flags_q))
		else $error("state changed without an item");

endmodule
